>>> rtl/ptst_pkg.sv
// Shared constants, codes and controller/datapath interface types for the slot timer.
package ptst_pkg;

   localparam int SLOTS      = 8;
   localparam int TICK_WIDTH = 32;

   localparam int PERIOD_W = 32;
   localparam int SLOT_W   = 3;
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMP_W    = (TICK_WIDTH > PERIOD_W) ? TICK_WIDTH : PERIOD_W;

   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_REGISTER = 2'd1;
   localparam logic [1:0] OP_UPDATE   = 2'd2;

   localparam logic [1:0] KIND_REPLY = 2'd0;
   localparam logic [1:0] KIND_DUE   = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic tick_inc;
      logic reg_write;
      logic scan_start;
      logic scan_step;
      logic emit_due;
      logic emit_done;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic scan_end;
      logic slot_due;
   } dp_status_type;

endpackage

>>> rtl/ptst_ctrl.sv
// Sequencing state machine for input acceptance and the slot scan.
module ptst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_operation,
   output logic                   req_stall,
   input  ptst_pkg::dp_status_type status,
   output ptst_pkg::ctl_cmd_type   cmd
);

   ptst_pkg::state_type state_ff;
   ptst_pkg::state_type state_in;
   logic                accept;

   assign req_stall = !((state_ff == ptst_pkg::ST_IDLE) && status.out_free);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptst_pkg::ST_IDLE: begin
            if (accept && (req_operation == ptst_pkg::OP_UPDATE)) begin
               state_in = ptst_pkg::ST_SCAN;
            end
         end
         ptst_pkg::ST_SCAN: begin
            if (status.scan_end && status.out_free) begin
               state_in = ptst_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ptst_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  ptst_pkg::OP_TICK:     cmd.tick_inc   = 1'b1;
                  ptst_pkg::OP_REGISTER: cmd.reg_write  = 1'b1;
                  ptst_pkg::OP_UPDATE:   cmd.scan_start = 1'b1;
                  default: begin
                  end
               endcase
            end
         end
         ptst_pkg::ST_SCAN: begin
            if (status.scan_end) begin
               cmd.emit_done = status.out_free;
            end else if (status.slot_due) begin
               cmd.emit_due  = status.out_free;
               cmd.scan_step = status.out_free;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
      endcase
   end

endmodule

>>> rtl/ptst_datapath.sv
// Tick counter, slot table, due comparison and response register.
module ptst_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ptst_pkg::PERIOD_W-1:0]     req_interval,
   input  logic [31:0]                       req_start_time,
   input  ptst_pkg::ctl_cmd_type             cmd,
   output ptst_pkg::dp_status_type           status,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [ptst_pkg::SLOT_W-1:0]       rsp_slot,
   output logic                              rsp_ok,
   output logic                              rsp_last
);

   logic [ptst_pkg::TICK_WIDTH-1:0] tick_ff, tick_in;
   logic [ptst_pkg::CNT_W-1:0]      fill_ff, fill_in;
   logic [ptst_pkg::CNT_W-1:0]      idx_ff, idx_in;
   logic [ptst_pkg::PERIOD_W-1:0]   period_ff [ptst_pkg::SLOTS];
   logic [ptst_pkg::PERIOD_W-1:0]   period_in [ptst_pkg::SLOTS];
   logic [ptst_pkg::TICK_WIDTH-1:0] last_ff [ptst_pkg::SLOTS];
   logic [ptst_pkg::TICK_WIDTH-1:0] last_in [ptst_pkg::SLOTS];

   logic                            valid_ff, valid_in;
   logic [1:0]                      kind_ff, kind_in;
   logic [ptst_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic                            ok_ff, ok_in;
   logic                            last_flag_ff, last_flag_in;

   logic                            full;
   logic [ptst_pkg::CMP_W-1:0]      start_wide;
   logic [ptst_pkg::TICK_WIDTH-1:0] start_stamp;
   logic [ptst_pkg::IDX_W-1:0]      fill_idx;
   logic [ptst_pkg::IDX_W-1:0]      scan_idx;
   logic [ptst_pkg::TICK_WIDTH-1:0] elapsed;

   assign full        = (fill_ff == ptst_pkg::CNT_W'(ptst_pkg::SLOTS));
   assign start_wide  = ptst_pkg::CMP_W'(req_start_time);
   assign start_stamp = start_wide[ptst_pkg::TICK_WIDTH-1:0];
   assign fill_idx    = fill_ff[ptst_pkg::IDX_W-1:0];
   assign scan_idx    = idx_ff[ptst_pkg::IDX_W-1:0];

   // Wrapping elapsed time of the slot under the scan pointer.
   assign elapsed = tick_ff - last_ff[scan_idx];

   assign status.out_free = !valid_ff || !rsp_stall;
   assign status.scan_end = (idx_ff == fill_ff);
   assign status.slot_due = ptst_pkg::CMP_W'(elapsed) > ptst_pkg::CMP_W'(period_ff[scan_idx]);

   always_comb begin
      tick_in      = tick_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      period_in    = period_ff;
      last_in      = last_ff;
      valid_in     = valid_ff && rsp_stall;
      kind_in      = kind_ff;
      slot_in      = slot_ff;
      ok_in        = ok_ff;
      last_flag_in = last_flag_ff;

      if (cmd.tick_inc) begin
         tick_in = tick_ff + 1'b1;
      end

      if (cmd.reg_write) begin
         valid_in     = 1'b1;
         kind_in      = ptst_pkg::KIND_REPLY;
         last_flag_in = 1'b1;
         ok_in        = !full;
         slot_in      = full ? '0 : ptst_pkg::SLOT_W'(fill_ff);
         if (!full) begin
            period_in[fill_idx] = req_interval;
            last_in[fill_idx]   = start_stamp;
            fill_in             = fill_ff + 1'b1;
         end
      end

      if (cmd.scan_start) begin
         idx_in = '0;
      end

      if (cmd.scan_step) begin
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.emit_due) begin
         valid_in          = 1'b1;
         kind_in           = ptst_pkg::KIND_DUE;
         slot_in           = ptst_pkg::SLOT_W'(idx_ff);
         ok_in             = 1'b0;
         last_flag_in      = 1'b0;
         last_in[scan_idx] = tick_ff;
      end

      if (cmd.emit_done) begin
         valid_in     = 1'b1;
         kind_in      = ptst_pkg::KIND_DONE;
         slot_in      = '0;
         ok_in        = 1'b0;
         last_flag_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         fill_ff  <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         tick_ff  <= tick_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff    <= period_in;
      last_ff      <= last_in;
      kind_ff      <= kind_in;
      slot_ff      <= slot_in;
      ok_ff        <= ok_in;
      last_flag_ff <= last_flag_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_slot  = slot_ff;
   assign rsp_ok    = ok_ff;
   assign rsp_last  = last_flag_ff;

endmodule

>>> rtl/periodic_task_slot_timer_core.sv
// Top level of the periodic task slot timer: controller plus datapath.
// A register word's reply is registered and presented in the cycle after acceptance.
// Tick and register words need no scan. An update word for N registered slots is
// accepted, visits each slot in turn and then loads the done word; output stalls
// hold the scan. Synchronous active-high reset clears the tick counter, the slot
// fill count, the scan pointer and the response valid; no clearing pass.

module periodic_task_slot_timer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic [ptst_pkg::PERIOD_W-1:0] req_interval,
   input  logic [31:0]                   req_start_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [ptst_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_ok,
   output logic                          rsp_last
);

   // Slots are handed out in ascending order and never freed, so the used
   // slots always form a prefix of the table. The datapath therefore keeps a
   // fill count instead of per-slot used flags: the lowest free slot is the
   // fill count itself and the table is full when it reaches the slot count.
   //
   // The controller accepts a word only while idle and while the response
   // register can take a new word, either empty or being drained in the same
   // cycle. An update word walks the scan pointer across the filled slots,
   // one per cycle; a due slot waits at the pointer until its word can be
   // loaded, then is restamped with the current tick. The done word closes
   // the scan and returns the controller to idle.

   ptst_pkg::ctl_cmd_type   cmd;
   ptst_pkg::dp_status_type status;

   ptst_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // The datapath owns all state but the controller's state register, including
   // the response register that decouples the scan from a stalled receiver.
   ptst_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_interval   (req_interval),
      .req_start_time (req_start_time),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_slot       (rsp_slot),
      .rsp_ok         (rsp_ok),
      .rsp_last       (rsp_last)
   );

endmodule

>>> rtl/ptst_checker.sv
// Port-level assertions for the slot timer and their bind to the top level.
module ptst_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [1:0]                    req_operation,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [1:0]                    rsp_kind,
   input logic [ptst_pkg::SLOT_W-1:0]   rsp_slot,
   input logic                          rsp_ok,
   input logic                          rsp_last
);

   // A stalled response word holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_slot)
         && $stable(rsp_ok) && $stable(rsp_last))
      else $error("stalled response word changed");

   // An accepted register word is answered in the next cycle with a final reply.
   a_reg_reply: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == ptst_pkg::OP_REGISTER)
         |=> rsp_valid && (rsp_kind == ptst_pkg::KIND_REPLY) && rsp_last)
      else $error("register word not answered by a reply");

   // A tick word on an empty output produces nothing.
   a_tick_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == ptst_pkg::OP_TICK) && !rsp_valid
         |=> !rsp_valid)
      else $error("tick word produced a response");

   // Due words are never final; done words are final and carry no slot.
   a_word_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == ptst_pkg::KIND_DUE) && !rsp_ok && !rsp_last)
         || ((rsp_kind == ptst_pkg::KIND_DONE) && !rsp_ok && rsp_last && (rsp_slot == '0))
         || ((rsp_kind == ptst_pkg::KIND_REPLY) && rsp_last && (rsp_ok || (rsp_slot == '0))))
      else $error("malformed response word");

endmodule

bind periodic_task_slot_timer_core ptst_checker u_ptst_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_slot      (rsp_slot),
   .rsp_ok        (rsp_ok),
   .rsp_last      (rsp_last)
);

>>> bench/tb_periodic_task_slot_timer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the periodic task slot timer core with its own slot table predictor.
module tb_periodic_task_slot_timer_core;

   // Operation code 3 is not used by the block. A word carrying it must be dropped
   // without a result and without touching the tick counter or the slot table.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // The run is aborted when this many cycles go by with no word accepted on either
   // channel. The slowest legal stretch is a long output stall or a long sender gap,
   // each far shorter than this limit, so this leaves a wide margin.
   localparam int IDLE_LIMIT = 2000;

   // Cycles to keep watching the result channel after the last expected word has
   // arrived. A reply is registered in the cycle after acceptance, so a stray word shows up well inside this.
   localparam int END_CYCLES = 12;

   localparam int RANDOM_WORDS = 430;

   typedef struct packed {
      logic [1:0]                  kind;
      logic [ptst_pkg::SLOT_W-1:0] slot;
      logic                        ok;
      logic                        last;
   } result_word_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [1:0]                    req_operation;
   logic [ptst_pkg::PERIOD_W-1:0] req_interval;
   logic [31:0]                   req_start_time;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [1:0]                    rsp_kind;
   logic [ptst_pkg::SLOT_W-1:0]   rsp_slot;
   logic                          rsp_ok;
   logic                          rsp_last;

   // Predicted copy of the block's state. The slot table entries that were never
   // written are held at zero here; they are never read because only used slots
   // take part in a scan.
   logic [ptst_pkg::TICK_WIDTH-1:0] tick_now;
   logic                            slot_busy     [ptst_pkg::SLOTS];
   logic [ptst_pkg::PERIOD_W-1:0]   slot_interval [ptst_pkg::SLOTS];
   logic [ptst_pkg::TICK_WIDTH-1:0] slot_stamp    [ptst_pkg::SLOTS];
   int                              slots_taken;

   // Result words that are due from the block, oldest first.
   result_word_type awaited_results [$];
   int              error_count = 0;

   // While set, the sender drives words back to back with no gaps.
   bit tx_burst;

   periodic_task_slot_timer_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_interval   (req_interval),
      .req_start_time (req_start_time),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_slot       (rsp_slot),
      .rsp_ok         (rsp_ok),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length for either side: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic void await_result(logic [1:0] kind, int slot, logic ok, logic last);
      result_word_type word;
      word.kind = kind;
      word.slot = ptst_pkg::SLOT_W'(slot);
      word.ok   = ok;
      word.last = last;
      awaited_results.push_back(word);
   endfunction

   // Applies one accepted request word to the predicted slot table and queues the
   // result words it must cause.
   function automatic void forecast_word(logic [1:0] op,
                                         logic [ptst_pkg::PERIOD_W-1:0] interval,
                                         logic [31:0] start_time);
      logic [ptst_pkg::TICK_WIDTH-1:0] elapsed;
      int                              free_slot;
      free_slot = -1;
      case (op)
         ptst_pkg::OP_TICK: begin
            tick_now = tick_now + 1'b1;
         end
         ptst_pkg::OP_REGISTER: begin
            // The lowest free slot wins; slots are never released.
            for (int i = ptst_pkg::SLOTS - 1; i >= 0; i--) begin
               if (!slot_busy[i]) free_slot = i;
            end
            if (free_slot < 0) begin
               await_result(ptst_pkg::KIND_REPLY, 0, 1'b0, 1'b1);
            end else begin
               slot_busy[free_slot]     = 1'b1;
               slot_interval[free_slot] = interval;
               slot_stamp[free_slot]    = ptst_pkg::TICK_WIDTH'(start_time);
               slots_taken++;
               await_result(ptst_pkg::KIND_REPLY, free_slot, 1'b1, 1'b1);
            end
         end
         ptst_pkg::OP_UPDATE: begin
            // A slot is due only when the wrapped elapsed time strictly exceeds
            // its interval; a due slot is restamped with the current tick.
            for (int i = 0; i < ptst_pkg::SLOTS; i++) begin
               if (slot_busy[i]) begin
                  elapsed = tick_now - slot_stamp[i];
                  if (elapsed > slot_interval[i]) begin
                     await_result(ptst_pkg::KIND_DUE, i, 1'b0, 1'b0);
                     slot_stamp[i] = tick_now;
                  end
               end
            end
            await_result(ptst_pkg::KIND_DONE, 0, 1'b0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   // Presents one request word after a random gap and waits until it is taken.
   // The valid is lowered only when a gap follows, so it never gets two
   // assignments in the same step.
   task automatic send_word(logic [1:0] op, logic [ptst_pkg::PERIOD_W-1:0] interval,
                            logic [31:0] start_time);
      int gap;
      gap = tx_burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_interval   <= interval;
      req_start_time <= start_time;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      forecast_word(op, interval, start_time);
   endtask

   // Holds off the sender until every queued result word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // Scans of an empty table give only the done word, and the unused operation
   // code is dropped even with every field bit set.
   task automatic test_empty_table();
      send_word(ptst_pkg::OP_UPDATE, '0, '0);
      send_word(OP_UNUSED, '1, '1);
      send_word(ptst_pkg::OP_UPDATE, '1, '1);
   endtask

   // Walks the firing rule from a known tick: zero interval, strict comparison,
   // the largest interval that never fires, and an elapsed time that wraps
   // because the start stamp lies ahead of the counter.
   task automatic test_due_rules();
      send_word(ptst_pkg::OP_REGISTER, '0, '0);
      send_word(ptst_pkg::OP_UPDATE, '0, '0);
      send_word(ptst_pkg::OP_TICK, '0, '0);
      send_word(ptst_pkg::OP_UPDATE, '0, '0);
      send_word(ptst_pkg::OP_REGISTER, '1, '1);
      send_word(ptst_pkg::OP_REGISTER, 32'hFFFF_FFFE, 32'd2);
      send_word(ptst_pkg::OP_REGISTER, 32'd3, 32'd1);
      send_word(ptst_pkg::OP_UPDATE, '0, '0);
      repeat (3) send_word(ptst_pkg::OP_TICK, $urandom(), $urandom());
      send_word(ptst_pkg::OP_UPDATE, '0, '0);
      send_word(ptst_pkg::OP_TICK, '0, '0);
      send_word(ptst_pkg::OP_UPDATE, '0, '0);
   endtask

   // Mostly ticks and scans with now and then a registration or an unused code; the interval and
   // start stamp of a registration are chosen so that slots really do fire.
   task automatic test_random_traffic(int count);
      logic [1:0]  op;
      logic [31:0] interval;
      logic [31:0] start_time;
      int          roll;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
         if ($urandom_range(0, 99) == 0) wait_drained();
         interval   = $urandom();
         start_time = $urandom();
         roll       = $urandom_range(0, 99);
         if (roll < 58) begin
            op = ptst_pkg::OP_TICK;
         end else if (roll < 88) begin
            op = ptst_pkg::OP_UPDATE;
         end else if (roll < 95) begin
            op = ptst_pkg::OP_REGISTER;
         end else begin
            op = OP_UNUSED;
         end
         if (op == ptst_pkg::OP_REGISTER) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
               interval = $urandom_range(0, 24);
            end else if (roll < 75) begin
               interval = $urandom_range(25, 200);
            end else if (roll < 88) begin
               interval = 32'hFFFF_FFFF - $urandom_range(0, 1);
            end
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
               start_time = 32'(tick_now - ptst_pkg::TICK_WIDTH'($urandom_range(0, 30)));
            end else if (roll < 60) begin
               start_time = 32'(tick_now + ptst_pkg::TICK_WIDTH'($urandom_range(0, 5)));
            end
         end
         send_word(op, interval, start_time);
      end
      tx_burst = 1'b0;
   endtask

   // Fills whatever is left of the table, then registers into a full table with
   // extreme field values and scans once more.
   task automatic test_table_full();
      while (slots_taken < ptst_pkg::SLOTS) begin
         send_word(ptst_pkg::OP_REGISTER, $urandom_range(0, 9), 32'(tick_now));
      end
      send_word(ptst_pkg::OP_REGISTER, '1, '1);
      send_word(ptst_pkg::OP_REGISTER, '0, '0);
      send_word(ptst_pkg::OP_UPDATE, '0, '0);
   endtask

   // Output side back-pressure: short runs of acceptance between stalls of random
   // length, with stretches where the stall stays low.
   initial begin : result_stall_gen
      int hold;
      bit steady;
      steady = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         repeat ($urandom_range(1, 6)) @(posedge clock);
         if ($urandom_range(0, 49) == 0) steady = !steady;
         hold = steady ? 0 : pick_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted result word is compared with the oldest queued expectation.
   // Inputs are driven with nonblocking assignments, so values read here at the
   // edge are the ones the block saw.
   always @(posedge clock) begin : result_checker
      result_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected result word: kind %0d slot %0d ok %0d last %0d",
                   rsp_kind, rsp_slot, rsp_ok, rsp_last);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind mismatch: expected %0d, actual %0d", want.kind, rsp_kind);
               error_count++;
            end
            if (rsp_slot !== want.slot) begin
               $error("slot mismatch: expected %0d, actual %0d", want.slot, rsp_slot);
               error_count++;
            end
            if (rsp_ok !== want.ok) begin
               $error("ok mismatch: expected %0d, actual %0d", want.ok, rsp_ok);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last mismatch: expected %0d, actual %0d", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Ends the run when neither channel moves a word for too long.
   initial begin : idle_watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      req_valid      <= 1'b0;
      req_operation  <= ptst_pkg::OP_TICK;
      req_interval   <= '0;
      req_start_time <= '0;
      reset          <= 1'b1;
      tx_burst = 1'b0;

      tick_now    = '0;
      slots_taken = 0;
      for (int i = 0; i < ptst_pkg::SLOTS; i++) begin
         slot_busy[i]     = 1'b0;
         slot_interval[i] = '0;
         slot_stamp[i]    = '0;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_due_rules();
      // The sender holds here until the block has answered everything so far.
      wait_drained();
      test_random_traffic(RANDOM_WORDS);
      test_table_full();

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
